[hw/rtl/hsv_pkg.sv]
// shared types and constants for the rgb to hsv converter
package hsv_pkg;

   localparam int CH_W   = 8;    // colour channel width
   localparam int HUE_W  = 9;    // hue field width
   localparam int NUM_W  = 18;   // dividend width
   localparam int DEN_W  = 9;    // divisor width
   localparam int Q_W    = 9;    // quotient width, one bit per divider stage
   localparam int HN_W   = 18;   // signed hue numerator width

   localparam logic signed [HN_W-1:0] HUE_STEP  = 18'sd60;
   localparam logic signed [HN_W-1:0] HUE_GREEN = 18'sd120;
   localparam logic signed [HN_W-1:0] HUE_BLUE  = 18'sd240;
   localparam logic signed [HN_W-1:0] HUE_FULL  = 18'sd360;
   localparam logic [HUE_W-1:0]       HUE_WRAP  = 9'd360;
   localparam logic [NUM_W-1:0]       SAT_SCALE = 18'd510;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   // per-word control and values carried alongside the dividers
   typedef struct packed {
      logic            valid;
      logic            gray;
      logic            black;
      logic [CH_W-1:0] bright;
   } side_type;

endpackage

[hw/rtl/hsv_front.sv]
// front end: max/min, sector pick and divider operands over two stages
module hsv_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic [hsv_pkg::CH_W-1:0]      red,
   input  logic [hsv_pkg::CH_W-1:0]      green,
   input  logic [hsv_pkg::CH_W-1:0]      blue,
   output hsv_pkg::side_type             side,
   output logic [hsv_pkg::NUM_W-1:0]     hue_num,
   output logic [hsv_pkg::DEN_W-1:0]     hue_den,
   output logic [hsv_pkg::NUM_W-1:0]     sat_num,
   output logic [hsv_pkg::DEN_W-1:0]     sat_den
);

   // stage one
   logic [hsv_pkg::CH_W-1:0] mx_in, mn_in, d_in;
   hsv_pkg::sector_type      sect_in;
   logic [hsv_pkg::CH_W:0]   diff_in;

   logic                     valid1_ff;
   logic [hsv_pkg::CH_W-1:0] mx1_ff, d1_ff;
   hsv_pkg::sector_type      sect1_ff;
   logic [hsv_pkg::CH_W:0]   diff1_ff;

   // stage two
   logic signed [hsv_pkg::HN_W-1:0] d_s, diff_s, off_s, n_s;
   logic [hsv_pkg::NUM_W-1:0]       hue_num_in, sat_num_in;
   hsv_pkg::side_type               side_in;

   hsv_pkg::side_type               side_ff;
   logic [hsv_pkg::NUM_W-1:0]       hue_num_ff, sat_num_ff;
   logic [hsv_pkg::DEN_W-1:0]       hue_den_ff, sat_den_ff;

   always_comb begin
      mx_in = red;
      if (green > mx_in) mx_in = green;
      if (blue > mx_in) mx_in = blue;
      mn_in = red;
      if (green < mn_in) mn_in = green;
      if (blue < mn_in) mn_in = blue;
      d_in = mx_in - mn_in;
      // ties go to red, then green
      if (mx_in == red) begin
         sect_in = hsv_pkg::SECT_RED;
      end else if (mx_in == green) begin
         sect_in = hsv_pkg::SECT_GREEN;
      end else begin
         sect_in = hsv_pkg::SECT_BLUE;
      end
      case (sect_in)
         hsv_pkg::SECT_RED:   diff_in = {1'b0, green} - {1'b0, blue};
         hsv_pkg::SECT_GREEN: diff_in = {1'b0, blue} - {1'b0, red};
         default:             diff_in = {1'b0, red} - {1'b0, green};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (enable) begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mx1_ff   <= mx_in;
         d1_ff    <= d_in;
         sect1_ff <= sect_in;
         diff1_ff <= diff_in;
      end
   end

   always_comb begin
      d_s    = signed'({{(hsv_pkg::HN_W-hsv_pkg::CH_W){1'b0}}, d1_ff});
      diff_s = signed'({{(hsv_pkg::HN_W-hsv_pkg::CH_W-1){diff1_ff[hsv_pkg::CH_W]}},
                        diff1_ff});
      case (sect1_ff)
         hsv_pkg::SECT_RED:   off_s = '0;
         hsv_pkg::SECT_GREEN: off_s = d_s * hsv_pkg::HUE_GREEN;
         default:             off_s = d_s * hsv_pkg::HUE_BLUE;
      endcase
      n_s = diff_s * hsv_pkg::HUE_STEP + off_s;
      // a negative red-sector hue wraps up by a full turn
      if (n_s < 0) n_s = n_s + d_s * hsv_pkg::HUE_FULL;
      hue_num_in = {n_s[hsv_pkg::NUM_W-2:0], 1'b0}
                   + {{(hsv_pkg::NUM_W-hsv_pkg::CH_W){1'b0}}, d1_ff};
      sat_num_in = {{(hsv_pkg::NUM_W-hsv_pkg::CH_W){1'b0}}, d1_ff} * hsv_pkg::SAT_SCALE
                   + {{(hsv_pkg::NUM_W-hsv_pkg::CH_W){1'b0}}, mx1_ff};
      side_in.valid  = valid1_ff;
      side_in.gray   = (d1_ff == '0);
      side_in.black  = (mx1_ff == '0);
      side_in.bright = mx1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (enable) begin
         side_ff.valid <= side_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff.gray   <= side_in.gray;
         side_ff.black  <= side_in.black;
         side_ff.bright <= side_in.bright;
         hue_num_ff     <= hue_num_in;
         sat_num_ff     <= sat_num_in;
         hue_den_ff     <= {d1_ff, 1'b0};
         sat_den_ff     <= {mx1_ff, 1'b0};
      end
   end

   assign side    = side_ff;
   assign hue_num = hue_num_ff;
   assign hue_den = hue_den_ff;
   assign sat_num = sat_num_ff;
   assign sat_den = sat_den_ff;

endmodule

[hw/rtl/hsv_div.sv]
// pipelined restoring divider, one quotient bit per stage
module hsv_div (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [hsv_pkg::NUM_W-1:0] num,
   input  logic [hsv_pkg::DEN_W-1:0] den,
   output logic [hsv_pkg::Q_W-1:0]   quo
);

   localparam int STAGES = hsv_pkg::Q_W;

   // the dividend is below den * 2**Q_W whenever den is nonzero, so its top bits seed the remainder
   logic [hsv_pkg::DEN_W-1:0] rem_ff  [STAGES];
   logic [hsv_pkg::Q_W-1:0]   low_ff  [STAGES];
   logic [hsv_pkg::Q_W-1:0]   q_ff    [STAGES];
   logic [hsv_pkg::DEN_W-1:0] den_ff  [STAGES];

   genvar i;
   generate
      for (i = 0; i < STAGES; i++) begin : g_stage
         logic [hsv_pkg::DEN_W-1:0] rem_prev, den_prev;
         logic [hsv_pkg::Q_W-1:0]   low_prev, q_prev;
         logic [hsv_pkg::DEN_W:0]   trial, diff;
         logic                      fits;
         logic [hsv_pkg::DEN_W-1:0] rem_in;
         logic [hsv_pkg::Q_W-1:0]   low_in, q_in;

         if (i == 0) begin : g_first
            assign rem_prev = num[hsv_pkg::NUM_W-1:hsv_pkg::Q_W];
            assign low_prev = num[hsv_pkg::Q_W-1:0];
            assign q_prev   = '0;
            assign den_prev = den;
         end else begin : g_next
            assign rem_prev = rem_ff[i-1];
            assign low_prev = low_ff[i-1];
            assign q_prev   = q_ff[i-1];
            assign den_prev = den_ff[i-1];
         end

         always_comb begin
            trial  = {rem_prev, low_prev[hsv_pkg::Q_W-1]};
            diff   = trial - {1'b0, den_prev};
            fits   = (trial >= {1'b0, den_prev});
            rem_in = fits ? diff[hsv_pkg::DEN_W-1:0] : trial[hsv_pkg::DEN_W-1:0];
            low_in = {low_prev[hsv_pkg::Q_W-2:0], 1'b0};
            q_in   = {q_prev[hsv_pkg::Q_W-2:0], fits};
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[i] <= rem_in;
               low_ff[i] <= low_in;
               q_ff[i]   <= q_in;
               den_ff[i] <= den_prev;
            end
         end
      end
   endgenerate

   assign quo = q_ff[STAGES-1];

endmodule

[hw/rtl/rgb_to_hsv_convert_core.sv]
// top level of the rgb to hsv converter: front end, two dividers, output stage
//
//   channel | ports                                                     | direction
//   --------+-----------------------------------------------------------+----------
//   request | req_valid req_stall req_red/green/blue                    | in
//   response| rsp_valid rsp_stall rsp_hue/saturation/brightness         | out
//
// one word accepted per cycle while req_stall is low; the pipeline is two front-end stages, nine
// divider stages (one quotient bit each) and the output register.
// the whole pipeline advances together; it holds only while a result sits in
// the output register and rsp_stall is high, and req_stall follows that.
// reset is synchronous and clears the valid bits only.
module rgb_to_hsv_convert_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [hsv_pkg::CH_W-1:0]     req_red,
   input  logic [hsv_pkg::CH_W-1:0]     req_green,
   input  logic [hsv_pkg::CH_W-1:0]     req_blue,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hsv_pkg::HUE_W-1:0]    rsp_hue,
   output logic [hsv_pkg::CH_W-1:0]     rsp_saturation,
   output logic [hsv_pkg::CH_W-1:0]     rsp_brightness
);

   localparam int DIV_STAGES = hsv_pkg::Q_W;

   logic                      advance;
   hsv_pkg::side_type         front_side;
   logic [hsv_pkg::NUM_W-1:0] hue_num, sat_num;
   logic [hsv_pkg::DEN_W-1:0] hue_den, sat_den;
   logic [hsv_pkg::Q_W-1:0]   hue_quo, sat_quo;

   hsv_pkg::side_type         side_ff [DIV_STAGES];

   logic [hsv_pkg::HUE_W-1:0] hue_in;
   logic [hsv_pkg::CH_W-1:0]  sat_in;
   logic                      rsp_valid_ff;
   logic [hsv_pkg::HUE_W-1:0] rsp_hue_ff;
   logic [hsv_pkg::CH_W-1:0]  rsp_sat_ff, rsp_bright_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   hsv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (req_valid),
      .red      (req_red),
      .green    (req_green),
      .blue     (req_blue),
      .side     (front_side),
      .hue_num  (hue_num),
      .hue_den  (hue_den),
      .sat_num  (sat_num),
      .sat_den  (sat_den)
   );

   hsv_div u_hue_div (
      .clock  (clock),
      .enable (advance),
      .num    (hue_num),
      .den    (hue_den),
      .quo    (hue_quo)
   );

   hsv_div u_sat_div (
      .clock  (clock),
      .enable (advance),
      .num    (sat_num),
      .den    (sat_den),
      .quo    (sat_quo)
   );

   // word flags and brightness ride alongside the divider stages
   genvar i;
   generate
      for (i = 0; i < DIV_STAGES; i++) begin : g_side
         hsv_pkg::side_type side_prev;
         if (i == 0) begin : g_first
            assign side_prev = front_side;
         end else begin : g_next
            assign side_prev = side_ff[i-1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               side_ff[i].valid <= 1'b0;
            end else if (advance) begin
               side_ff[i].valid <= side_prev.valid;
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               side_ff[i].gray   <= side_prev.gray;
               side_ff[i].black  <= side_prev.black;
               side_ff[i].bright <= side_prev.bright;
            end
         end
      end
   endgenerate

   always_comb begin
      // gray gives hue 0, and a hue that rounds up to a full turn wraps to 0
      if (side_ff[DIV_STAGES-1].gray) begin
         hue_in = '0;
      end else if (hue_quo >= hsv_pkg::HUE_WRAP) begin
         hue_in = hue_quo - hsv_pkg::HUE_WRAP;
      end else begin
         hue_in = hue_quo;
      end
      sat_in = side_ff[DIV_STAGES-1].black ? '0 : sat_quo[hsv_pkg::CH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= side_ff[DIV_STAGES-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hue_ff    <= hue_in;
         rsp_sat_ff    <= sat_in;
         rsp_bright_ff <= side_ff[DIV_STAGES-1].bright;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_sat_ff;
   assign rsp_brightness = rsp_bright_ff;

   a_hue_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue < hsv_pkg::HUE_WRAP))
      else $error("hue out of range");

   a_black_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_brightness == '0) |-> (rsp_saturation == '0 && rsp_hue == '0))
      else $error("black word with nonzero hue or saturation");

   a_unsat_gray : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturation == '0) |-> (rsp_hue == '0))
      else $error("zero saturation with nonzero hue");

   a_no_idle_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output register");

   a_hold_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_hue)
                                    && $stable(rsp_saturation)))
      else $error("stalled word changed");

endmodule
